// File: rtl/core/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared widths, register indexes and header codes of the message packet
// framer.
// ----------------------------------------------------------------------------
package mpf_pkg;

   localparam int BYTE_W          = 8;
   localparam int DEF_PAYLOAD_BYTES = 8;
   localparam int DEF_PACKET_BYTES  = 16;

   // header occupies packet positions 0 .. HEADER_LEN-1
   localparam int HEADER_LEN = 7;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type FLAG_MORE = 8'h02;
   localparam byte_type FLAG_LAST = 8'h04;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_START_BYTE  = 3'd0;
   localparam csr_idx_type CSR_SIGNAL_BYTE = 3'd1;
   localparam csr_idx_type CSR_SOURCE_ADDR = 3'd2;
   localparam csr_idx_type CSR_OWN_ADDR    = 3'd3;
   localparam csr_idx_type CSR_ORDER_CODE  = 3'd4;

   // header byte positions
   typedef logic [2:0] hdr_pos_type;

   localparam hdr_pos_type HDR_START  = 3'd0;
   localparam hdr_pos_type HDR_SIGNAL = 3'd1;
   localparam hdr_pos_type HDR_SOURCE = 3'd2;
   localparam hdr_pos_type HDR_OWN    = 3'd3;
   localparam hdr_pos_type HDR_ORDER  = 3'd4;
   localparam hdr_pos_type HDR_FLAGS  = 3'd5;
   localparam hdr_pos_type HDR_ZERO   = 3'd6;

endpackage

// File: rtl/core/mpf_if.sv
// ----------------------------------------------------------------------------
// mpf_req_if / mpf_rsp_if
// Valid/ready channels of the message packet framer: payload bytes in,
// packet bytes out.
// ----------------------------------------------------------------------------
interface mpf_req_if
   import mpf_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface mpf_rsp_if
   import mpf_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     packet_end;
   logic     final_packet;

   modport source (output valid, output out_byte, output packet_end,
                   output final_packet, input ready);
   modport sink   (input valid, input out_byte, input packet_end,
                   input final_packet, output ready);
endinterface

// File: rtl/core/mpf_chunk_mem.sv
// ----------------------------------------------------------------------------
// mpf_chunk_mem
// Chunk buffer: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpf_chunk_mem
   import mpf_pkg::*;
#(
   parameter int DEPTH  = DEF_PAYLOAD_BYTES,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  byte_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output byte_type          rd_data
);

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/message_packet_framer.sv
// ----------------------------------------------------------------------------
// message_packet_framer
// Gathers payload bytes into a chunk buffer and frames each full chunk, or
// the tail of a message, into one fixed-size packet with header and parity.
// ----------------------------------------------------------------------------
// Flow: an item that closes a chunk moves the block to its emit state; the
//   packet bytes then pass through the output register, one byte per cycle
//   while the receiver keeps ready high. An item that does not close a chunk
//   leaves the input ready for the next item; one that does holds the input
//   until the whole packet is out, set by the single output byte lane.
// Reset: synchronous, active high; clears fill count, registers and output.
module message_packet_framer
   import mpf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
   parameter int PACKET_BYTES  = DEF_PACKET_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   mpf_req_if.sink        req_ch,
   mpf_rsp_if.source      rsp_ch,
   input  logic           csr_we,
   input  csr_idx_type    csr_index,
   input  byte_type       csr_wdata
);

   localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);
   localparam int POS_W  = $clog2(PACKET_BYTES);
   localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   localparam logic [POS_W-1:0] POS_PARITY = POS_W'(PACKET_BYTES - 1);
   localparam logic [CMP_W-1:0] HDR_LEN_C  = CMP_W'(HEADER_LEN);
   localparam logic [CMP_W-1:0] PAYLOAD_C  = CMP_W'(PAYLOAD_BYTES);
   localparam logic [CNT_W-1:0] FILL_FULL  = CNT_W'(PAYLOAD_BYTES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   // configuration registers
   byte_type start_ff, signal_ff, source_ff, own_ff, order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         signal_ff <= '0;
         source_ff <= '0;
         own_ff    <= '0;
         order_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:  start_ff  <= csr_wdata;
            CSR_SIGNAL_BYTE: signal_ff <= csr_wdata;
            CSR_SOURCE_ADDR: source_ff <= csr_wdata;
            CSR_OWN_ADDR:    own_ff    <= csr_wdata;
            CSR_ORDER_CODE:  order_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   logic             state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             final_ff, final_in;
   byte_type         parity_ff, parity_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_byte_ff, rsp_byte_in;
   logic     rsp_end_ff, rsp_end_in;
   logic     rsp_final_ff, rsp_final_in;

   logic              accept;
   logic              closes;
   logic [CNT_W-1:0]  fill_inc;
   logic              advance;
   byte_type          pkt_byte;
   byte_type          rd_data;
   logic [CMP_W-1:0]  pos_cmp, idx_cur, pos_next_cmp, idx_next;
   logic              payload_cur, payload_next;
   logic [ADDR_W-1:0] rd_addr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign fill_inc     = fill_ff + CNT_W'(1);
   assign closes       = req_ch.message_end || (fill_inc == FILL_FULL);
   assign advance      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   mpf_chunk_mem #(
      .DEPTH  (PAYLOAD_BYTES),
      .ADDR_W (ADDR_W)
   ) u_chunk_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_ch.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // payload position of the current byte
   assign pos_cmp     = CMP_W'(pos_ff);
   assign idx_cur     = pos_cmp - HDR_LEN_C;
   assign payload_cur = (pos_cmp >= HDR_LEN_C) && (idx_cur < CMP_W'(fill_ff));

   // read ahead, for the position held next cycle
   assign pos_next_cmp = CMP_W'(pos_in);
   assign idx_next     = pos_next_cmp - HDR_LEN_C;
   assign payload_next = (pos_next_cmp >= HDR_LEN_C) && (idx_next < PAYLOAD_C);
   assign rd_addr      = payload_next ? idx_next[ADDR_W-1:0] : '0;

   always_comb begin
      pkt_byte = '0;
      if (pos_cmp < HDR_LEN_C) begin
         case (pos_ff[2:0])
            HDR_START:  pkt_byte = start_ff;
            HDR_SIGNAL: pkt_byte = signal_ff;
            HDR_SOURCE: pkt_byte = source_ff;
            HDR_OWN:    pkt_byte = own_ff;
            HDR_ORDER:  pkt_byte = order_ff;
            HDR_FLAGS:  pkt_byte = final_ff ? FLAG_LAST : FLAG_MORE;
            HDR_ZERO:   pkt_byte = '0;
            default:    pkt_byte = '0;
         endcase
      end else if (payload_cur) begin
         pkt_byte = rd_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      final_in     = final_ff;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_final_in = rsp_final_ff;

      if (accept) begin
         fill_in = fill_inc;
         if (closes) begin
            state_in  = ST_EMIT;
            final_in  = req_ch.message_end;
            pos_in    = '0;
            parity_in = '0;
         end
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_final_in = final_ff;
         if (pos_ff == POS_PARITY) begin
            rsp_byte_in = parity_ff;
            rsp_end_in  = 1'b1;
            state_in    = ST_IDLE;
            fill_in     = '0;
            pos_in      = '0;
         end else begin
            rsp_byte_in = pkt_byte;
            rsp_end_in  = 1'b0;
            parity_in   = parity_ff ^ pkt_byte;
            pos_in      = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pos_ff       <= '0;
         final_ff     <= 1'b0;
         parity_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         final_ff     <= final_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_byte_ff;
   assign rsp_ch.packet_end   = rsp_end_ff;
   assign rsp_ch.final_packet = rsp_final_ff;

   // ------------------------------------------------------------------------
   // checks

   a_fill_room : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FILL_FULL))
      else $error("chunk buffer full while taking items");

   a_close_emits : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.message_end) |=> (state_ff == ST_EMIT && final_ff))
      else $error("message end did not start a final packet");

   a_parity_closes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> (state_ff == ST_IDLE || pos_ff < POS_PARITY))
      else $error("packet end shown while a packet is half emitted");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pos_ff == '0))
      else $error("byte position not cleared between packets");

endmodule

// File: tb/tb_message_packet_framer.sv
// ----------------------------------------------------------------------------
// tb_message_packet_framer
// Drives messages into the framer byte by byte, predicts every packet byte
// (header, flags, payload, zero fill, parity) and checks each output item in
// order. Header registers are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_message_packet_framer;
   import mpf_pkg::*;

   localparam int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES;
   localparam int PACKET_BYTES  = DEF_PACKET_BYTES;
   localparam int PHASE_ITEMS   = 75;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      byte_type out_byte;
      logic     packet_end;
      logic     final_packet;
   } packet_byte_type;

   // pinned rows carry a hand-worked flags and parity byte
   typedef struct packed {
      byte_type data;
      logic     msg_end;
      logic     pinned;
      byte_type flags;
      byte_type parity;
   } step_row_type;

   localparam int DIRECTED_ROWS = 23;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   csr_idx_type csr_index;
   byte_type    csr_wdata;

   mpf_req_if req_if ();
   mpf_rsp_if rsp_if ();

   message_packet_framer #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .PACKET_BYTES  (PACKET_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   byte_type    start_byte     = '0;
   byte_type    signal_byte    = '0;
   byte_type    source_address = '0;
   byte_type    own_address    = '0;
   byte_type    order_code     = '0;
   byte_type    chunk_buffer [PAYLOAD_BYTES];
   int unsigned fill_count     = 0;

   packet_byte_type packet_bytes_due [$];
   int              mismatch_count = 0;
   int              burst_left     = 0;

   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'hFF, 1'b1, 1'b1, FLAG_LAST, 8'hFB},
      '{8'h00, 1'b1, 1'b1, FLAG_LAST, 8'h04},
      '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h02, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h04, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h08, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h10, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h40, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h80, 1'b1, 1'b1, FLAG_LAST, 8'hFB},
      '{8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h55, 1'b0, 1'b1, FLAG_MORE, 8'h02},
      '{8'h7E, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h81, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFF, 1'b1, 1'b1, FLAG_LAST, 8'h04},
      '{8'hC3, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h3C, 1'b1, 1'b0, 8'h00, 8'h00}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gather one payload byte; emit a whole packet when the chunk closes
   function automatic void frame_payload_byte(byte_type data, logic msg_end);
      byte_type    parity;
      byte_type    b;
      int unsigned idx;
      parity = '0;
      if (fill_count < PAYLOAD_BYTES) begin
         chunk_buffer[fill_count] = data;
         fill_count++;
      end
      if (!msg_end && fill_count < PAYLOAD_BYTES)
         return;
      for (int p = 0; p < PACKET_BYTES - 1; p++) begin
         case (p)
            HDR_START:  b = start_byte;
            HDR_SIGNAL: b = signal_byte;
            HDR_SOURCE: b = source_address;
            HDR_OWN:    b = own_address;
            HDR_ORDER:  b = order_code;
            HDR_FLAGS:  b = msg_end ? FLAG_LAST : FLAG_MORE;
            HDR_ZERO:   b = '0;
            default: begin
               idx = p - HEADER_LEN;
               // zero-fill past the gathered bytes and past the chunk
               b = (idx < fill_count && idx < PAYLOAD_BYTES) ? chunk_buffer[idx] : '0;
            end
         endcase
         parity ^= b;
         packet_bytes_due.push_back('{out_byte: b, packet_end: 1'b0, final_packet: msg_end});
      end
      packet_bytes_due.push_back('{out_byte: parity, packet_end: 1'b1,
                                   final_packet: msg_end});
      fill_count = 0;
   endfunction

   task automatic report(string field, int got, int want);
      $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      packet_byte_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (packet_bytes_due.size() == 0) begin
            report("unexpected item", rsp_if.out_byte, 0);
         end else begin
            want = packet_bytes_due.pop_front();
            if (rsp_if.out_byte !== want.out_byte)
               report("out_byte", rsp_if.out_byte, want.out_byte);
            if (rsp_if.packet_end !== want.packet_end)
               report("packet_end", rsp_if.packet_end, want.packet_end);
            if (rsp_if.final_packet !== want.final_packet)
               report("final_packet", rsp_if.final_packet, want.final_packet);
         end
      end
   end

   // receiver stalls on a rotating pattern, reloaded after each random run
   initial begin
      logic [15:0] stall_pat;
      int          stall_run;
      stall_pat = '1;
      stall_run = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_run == 0) begin
            stall_run = $urandom_range(40, 200);
            case ($urandom_range(0, 2))
               0:       stall_pat = '1;
               1:       stall_pat = 16'($urandom);
               default: stall_pat = ~(16'h1 << $urandom_range(0, 15));
            endcase
         end else begin
            stall_run--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
         end
         rsp_if.ready <= stall_pat[15];
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(byte_type data, logic msg_end, logic pinned = 1'b0,
                            byte_type flags = '0, byte_type parity = '0);
      int gap;
      int base;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 10);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= data;
      req_if.message_end <= msg_end;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      frame_payload_byte(data, msg_end);
      if (pinned) begin
         base = packet_bytes_due.size() - PACKET_BYTES;
         packet_bytes_due[base + HDR_FLAGS].out_byte = flags;
         packet_bytes_due[base + PACKET_BYTES - 1].out_byte = parity;
      end
      @(negedge clock);
   endtask

   // hold the sender until every packet byte is out, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      while (packet_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, byte_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_START_BYTE:  start_byte     = val;
         CSR_SIGNAL_BYTE: signal_byte    = val;
         CSR_SOURCE_ADDR: source_address = val;
         CSR_OWN_ADDR:    own_address    = val;
         CSR_ORDER_CODE:  order_code     = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(byte_type s, byte_type sig, byte_type src, byte_type own,
                            byte_type ord);
      drain();
      write_reg(CSR_START_BYTE, s);
      write_reg(CSR_SIGNAL_BYTE, sig);
      write_reg(CSR_SOURCE_ADDR, src);
      write_reg(CSR_OWN_ADDR, own);
      write_reg(CSR_ORDER_CODE, ord);
      // unmapped indexes must leave the header untouched
      for (int i = CSR_ORDER_CODE + 1; i < 2**CSR_IDX_W; i++)
         write_reg(csr_idx_type'(i), byte_type'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic send_message(output int sent);
      int len;
      // favor chunk-aligned lengths so a full chunk often ends the message
      if ($urandom_range(0, 4) == 0)
         len = PAYLOAD_BYTES * $urandom_range(1, 3);
      else
         len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++)
         send_byte(byte_type'($urandom_range(0, 255)), i == len - 1);
      sent = len;
   endtask

   initial begin
      int sent;
      int phase_sent;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_START_BYTE;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.message_end = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // header registers still hold their reset value here
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].msg_end,
                   directed_rows[i].pinned, directed_rows[i].flags,
                   directed_rows[i].parity);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2:       configure(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
            default: configure(byte_type'($urandom), byte_type'($urandom),
                               byte_type'($urandom), byte_type'($urandom),
                               byte_type'($urandom));
         endcase
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            send_message(sent);
            phase_sent += sent;
            if (phase == 1 && phase_sent >= PHASE_ITEMS / 2 &&
                phase_sent - sent < PHASE_ITEMS / 2)
               drain();
         end
      end
      configure('0, '0, '0, '0, '0);
      send_byte(8'hFF, 1'b1);

      req_if.valid <= 1'b0;
      while (packet_bytes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
